FILE: hdl/assert_macros.svh
// Assertion macros for the double-ended queue checker.
// Expects signals clk and rst_n in the scope of use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define BDEQ_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define BDEQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/bdeq_pkg.sv
// Shared constants, types and ring index helper for the double-ended queue.
// No dependencies.
`default_nettype none

package bdeq_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // fixed field widths of the word layout
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int RES_W       = STATUS_W + 1 + 2 * COUNT_W + 2 * VALUE_WIDTH;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  // bit offsets of the result fields in out_tdata
  localparam int EMPTY_BIT = STATUS_W;
  localparam int CNT_LSB   = STATUS_W + 1;
  localparam int FRONT_LSB = CNT_LSB + COUNT_W;
  localparam int BACK_LSB  = FRONT_LSB + VALUE_WIDTH;
  localparam int REM_LSB   = BACK_LSB + VALUE_WIDTH;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP        = 2'd2,
    CMD_REMOVE     = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    status_t                status;
    logic                   is_empty;
    logic [COUNT_W-1:0]     count;
    logic [VALUE_WIDTH-1:0] front_value;
    logic [VALUE_WIDTH-1:0] back_value;
    logic [COUNT_W-1:0]     removed_count;
  } result_t;

  // Ring position of the element ofs places behind base; the wrap is correct for ofs up to DEPTH.
  function automatic logic [IDX_W-1:0] ring_idx(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/bdeq_ram.sv
// Generic slot memory: one write port, two registered read ports.
// No dependencies.
`default_nettype none

module bdeq_ram #(
  parameter int DEPTH_P = 16,
  parameter int WIDTH_P = 32
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH_P)-1:0] waddr,
  input  wire logic [WIDTH_P-1:0]         wdata,
  input  wire logic [$clog2(DEPTH_P)-1:0] ra_addr,
  output      logic [WIDTH_P-1:0]         ra_data,
  input  wire logic [$clog2(DEPTH_P)-1:0] rb_addr,
  output      logic [WIDTH_P-1:0]         rb_data
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

`default_nettype wire

FILE: hdl/bdeq_ctrl.sv
// Command sequencer of the double-ended queue: ring pointers, remove scan.
// Depends on bdeq_pkg; drives the ports of bdeq_ram.
`default_nettype none

module bdeq_ctrl import bdeq_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cmd_valid,
  output      logic                   cmd_ready,
  input  wire cmd_t                   cmd,
  input  wire logic [VALUE_WIDTH-1:0] value,
  output      logic                   res_valid,
  input  wire logic                   res_ready,
  output      result_t                res,
  output      logic                   ram_we,
  output      logic [IDX_W-1:0]       ram_waddr,
  output      logic [VALUE_WIDTH-1:0] ram_wdata,
  output      logic [IDX_W-1:0]       ram_ra_addr,
  input  wire logic [VALUE_WIDTH-1:0] ram_ra_data,
  output      logic [IDX_W-1:0]       ram_rb_addr,
  input  wire logic [VALUE_WIDTH-1:0] ram_rb_data
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_READ, S_RESP} state_t;

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       front_r, front_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  status_t                status_r, status_nxt;
  logic [CNT_W-1:0]       removed_r, removed_nxt;
  logic [CNT_W-1:0]       k_r, k_nxt;
  logic [CNT_W-1:0]       kept_r, kept_nxt;
  logic                   pend_r, pend_nxt;

  logic issue;
  logic match;
  logic is_empty;

  assign issue    = (k_r < cnt_r);
  assign match    = (ram_ra_data == val_r);
  assign is_empty = (cnt_r == '0);

  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);

  // scan reads walk the ring, otherwise point at both ends
  assign ram_ra_addr = (state_r == S_SCAN) ? ring_idx(front_r, k_r) : front_r;
  assign ram_rb_addr = ring_idx(front_r, cnt_r - CNT_W'(1));

  always_comb begin
    res.status        = status_r;
    res.is_empty      = is_empty;
    res.count         = COUNT_W'(cnt_r);
    res.front_value   = is_empty ? '0 : ram_ra_data;
    res.back_value    = is_empty ? '0 : ram_rb_data;
    res.removed_count = COUNT_W'(removed_r);
  end

  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    cnt_nxt     = cnt_r;
    val_nxt     = val_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    k_nxt       = k_r;
    kept_nxt    = kept_r;
    pend_nxt    = pend_r;
    ram_we      = 1'b0;
    ram_waddr   = ring_idx(front_r, kept_r);
    ram_wdata   = ram_ra_data;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          val_nxt     = value;
          status_nxt  = ST_OK;
          removed_nxt = '0;
          k_nxt       = '0;
          kept_nxt    = '0;
          pend_nxt    = 1'b0;
          state_nxt   = S_READ;
          case (cmd) inside
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              if (cnt_r == CNT_W'(DEPTH)) begin
                status_nxt = ST_PUSH_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = value;
                cnt_nxt   = cnt_r + CNT_W'(1);
                if (cmd == CMD_PUSH_FRONT) begin
                  front_nxt = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - IDX_W'(1);
                  ram_waddr = front_nxt;
                end else begin
                  ram_waddr = ring_idx(front_r, cnt_r);
                end
              end
            end
            CMD_POP: begin
              if (is_empty) begin
                status_nxt = ST_POP_EMPTY;
              end else begin
                if (!value[0]) begin
                  front_nxt = ring_idx(front_r, CNT_W'(1));
                end
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
            default: state_nxt = S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        // read ahead one slot, compact the slot read last cycle
        k_nxt    = k_r + CNT_W'(issue);
        pend_nxt = issue;
        if (pend_r) begin
          if (match) begin
            removed_nxt = removed_r + CNT_W'(1);
          end else begin
            ram_we   = 1'b1;
            kept_nxt = kept_r + CNT_W'(1);
          end
        end
        if (!issue && !pend_r) begin
          cnt_nxt   = kept_r;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_RESP;
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    k_r       <= k_nxt;
    kept_r    <= kept_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/bounded_double_ended_queue.sv
// Top level of the bounded double-ended queue: sequencer, slot memory, result register.
// Depends on bdeq_pkg, bdeq_ctrl and bdeq_ram.
//
//   channel  direction  fields (lowest bit first)
//   in_      slave      tuser: cmd[1:0]; tdata: value[31:0]
//   out_     master     tdata: status, is_empty, count, front_value, back_value,
//                              removed_count, zero pad to 80 bits
//
// With the result register free, a push or pop passes through the read and response
// states before the next acceptance; a remove first scans every stored slot through the
// first slot-read port, so it takes longer as count grows.
// Reset (rst_n low, synchronous) empties the queue; slot contents are kept as is.
// A result waiting in the output register does not stop the next word being taken;
// only a second finished result waits in the sequencer until the register frees.
`default_nettype none

module bounded_double_ended_queue import bdeq_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // value
  input  wire logic [CMD_W-1:0]       in_tuser,   // cmd
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata   // status, is_empty, count, front_value,
                                                  // back_value, removed_count
);

  logic                   res_valid;
  logic                   res_ready;
  result_t                res;
  result_t                out_res_r;
  logic                   out_tvalid_r;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [IDX_W-1:0]       ram_ra_addr;
  logic [VALUE_WIDTH-1:0] ram_ra_data;
  logic [IDX_W-1:0]       ram_rb_addr;
  logic [VALUE_WIDTH-1:0] ram_rb_data;

  bdeq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (in_tvalid),
    .cmd_ready   (in_tready),
    .cmd         (cmd_t'(in_tuser)),
    .value       (in_tdata[VALUE_WIDTH-1:0]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_ra_addr (ram_ra_addr),
    .ram_ra_data (ram_ra_data),
    .ram_rb_addr (ram_rb_addr),
    .ram_rb_data (ram_rb_data)
  );

  bdeq_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (VALUE_WIDTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .ra_addr (ram_ra_addr),
    .ra_data (ram_ra_data),
    .rb_addr (ram_rb_addr),
    .rb_data (ram_rb_data)
  );

  // load a new result whenever the register is empty or being drained
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({out_res_r.removed_count,
                                    out_res_r.back_value,
                                    out_res_r.front_value,
                                    out_res_r.count,
                                    out_res_r.is_empty,
                                    out_res_r.status});

endmodule

`default_nettype wire

FILE: hdl/bdeq_checker.sv
// Port-level checks on the double-ended queue result channel, bound to the top level.
// Depends on bdeq_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module bdeq_checker import bdeq_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  logic                     stalled;
  logic                     out_empty;
  logic [COUNT_W-1:0]       out_count;
  logic [2*VALUE_WIDTH-1:0] out_ends;

  assign stalled   = out_tvalid && !out_tready;
  assign out_empty = out_tdata[EMPTY_BIT];
  assign out_count = out_tdata[CNT_LSB +: COUNT_W];
  assign out_ends  = out_tdata[FRONT_LSB +: 2*VALUE_WIDTH];

  `BDEQ_ASSERT_RST(a_reset_idle, !rst_n |=> !out_tvalid, "result valid after reset")
  `BDEQ_ASSERT_CLK(a_hold, stalled |=> out_tvalid && $stable(out_tdata), "stalled word changed")
  `BDEQ_ASSERT_CLK(a_empty_flag, out_tvalid |-> (out_empty == (out_count == '0)), "empty flag off")
  `BDEQ_ASSERT_CLK(a_count_max, out_tvalid |-> (out_count <= COUNT_W'(DEPTH)), "count above depth")
  `BDEQ_ASSERT_CLK(a_empty_zero, out_tvalid && out_empty |-> (out_ends == '0), "ends not zero")

endmodule

bind bounded_double_ended_queue bdeq_checker u_bdeq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
